/* rtl/sme_pkg.sv */
// Shared constants and types for the stack machine execute block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

    localparam int STACK_DEPTH   = 16;
    localparam int TABLE_ENTRIES = 4;

    localparam int DATA_W   = 32;
    localparam int KEY_W    = 20;
    localparam int VAL_W    = 4;
    localparam int OP_W     = 4;
    localparam int FAULT_W  = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;
    localparam int ADDR_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);

    // opcodes
    localparam logic [OP_W-1:0] OP_PUSH = 4'd1;
    localparam logic [OP_W-1:0] OP_SHOW = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD  = 4'd3;
    localparam logic [OP_W-1:0] OP_MULT = 4'd4;
    localparam logic [OP_W-1:0] OP_END  = 4'd5;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ZERO    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_ZERO  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_ONE   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TWO   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THREE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_THREE = 4'd7;

    // controller to datapath
    typedef struct packed {
        logic                latch;     // capture the accepted instruction
        logic                push;      // push looked-up value
        logic                rd_nos;    // read second stack entry
        logic                alu;       // compute add or multiply
        logic                wr_alu;    // write back result, drop one entry
        logic                set_halt;
        logic                load_out;  // load result beat
        logic [FAULT_W-1:0]  fault;
        logic                shown;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            halted;
        logic            cnt_zero;
        logic            cnt_lt2;
        logic            cnt_full;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/stack_machine_execute.sv */
// Top level of the stack machine execute block.
// Depends on sme_pkg, sme_ctrl and sme_datapath.
//
// Usage:
//   s_ channel carries one instruction per beat (s_req_type, s_operand_address).
//   m_ channel returns one result beat per instruction: top of stack, show
//   flag, halted flag and fault code.
//   cfg channel writes the four key/value table entries by index; cfg_ready
//   is always high. Write only while no instruction is in flight.
//   Each instruction steps through decode and result; add and multiply also
//   pass through read and write, since the second stack entry comes from a
//   registered read of the stack RAM. A new instruction is accepted only after
//   the previous one has loaded its result beat into the output register.
//   The top of stack is held in a register, so only add and multiply read RAM.
//   When the receiver stalls, the result beat holds in the output register;
//   the next instruction is still accepted and runs, then waits for the slot.
//   Reset clears the table, the stack pointer, the halt flag and all handshake
//   state. No clearing pass: stack entries are written before they are read.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_execute
    import sme_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OP_W-1:0]       s_req_type,
    input  wire logic [KEY_W-1:0]      s_operand_address,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [DATA_W-1:0]   m_top_value,
    output logic                       m_top_shown,
    output logic                       m_halted,
    output logic [FAULT_W-1:0]         m_fault,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sme_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_req_type        (s_req_type),
        .s_operand_address (s_operand_address),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_top_value       (m_top_value),
        .m_top_shown       (m_top_shown),
        .m_halted          (m_halted),
        .m_fault           (m_fault)
    );

endmodule

`default_nettype wire

/* rtl/sme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sme_ctrl.sv */
// Instruction sequencer for the stack machine execute block.
// Depends on sme_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module sme_ctrl
    import sme_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_WRITE,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic               shown_reg, shown_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        fault_next   = fault_reg;
        shown_next   = shown_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.fault    = fault_reg;
        cmd.shown    = shown_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                fault_next = FAULT_NONE;
                shown_next = 1'b0;
                state_next = S_RESULT;
                if (!status.halted) begin
                    case (status.op)
                        OP_PUSH: begin
                            if (status.cnt_full) begin
                                fault_next = FAULT_OVER;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        OP_SHOW: begin
                            if (status.cnt_zero) begin
                                fault_next = FAULT_UNDER;
                            end else begin
                                shown_next = 1'b1;
                            end
                        end
                        OP_ADD, OP_MULT: begin
                            if (status.cnt_lt2) begin
                                fault_next = FAULT_UNDER;
                            end else begin
                                cmd.rd_nos = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_END: begin
                            cmd.set_halt = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                cmd.alu    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                cmd.wr_alu = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fault_reg   <= FAULT_NONE;
            shown_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fault_reg   <= fault_next;
            shown_reg   <= shown_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sme_datapath.sv */
// Datapath: config table, stack store and pointer, ALU, result registers.
// Depends on sme_pkg and sme_ram.
`timescale 1ns / 1ps
`default_nettype none

module sme_datapath
    import sme_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire logic [OP_W-1:0]       s_req_type,
    input  wire logic [KEY_W-1:0]      s_operand_address,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic signed [DATA_W-1:0]   m_top_value,
    output logic                       m_top_shown,
    output logic                       m_halted,
    output logic [FAULT_W-1:0]         m_fault
);

    logic [KEY_W-1:0]   key_reg [TABLE_ENTRIES];
    logic [VAL_W-1:0]   val_reg [TABLE_ENTRIES];

    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   addr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               halt_reg;
    logic [DATA_W-1:0]  top_reg;
    logic [DATA_W-1:0]  alu_reg, alu_next;

    logic [DATA_W-1:0]  out_top_reg;
    logic               out_shown_reg;
    logic               out_halted_reg;
    logic [FAULT_W-1:0] out_fault_reg;

    logic [VAL_W-1:0]   lookup_val;
    logic [DATA_W-1:0]  push_val;
    logic [CNT_W-1:0]   cnt_m2;
    logic [ADDR_W-1:0]  nos_addr;
    logic [DATA_W-1:0]  nos_data;
    logic [DATA_W-1:0]  prod;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;

    // config writes; entries past TABLE_ENTRIES are never searched
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                key_reg[i] <= '0;
                val_reg[i] <= '0;
            end
        end else if (cfg_we && (cfg_index <= CFG_VALUE_THREE)) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(i)) begin
                    if (cfg_index[0]) begin
                        val_reg[i] <= cfg_data[VAL_W-1:0];
                    end else begin
                        key_reg[i] <= cfg_data[KEY_W-1:0];
                    end
                end
            end
        end
    end

    // lowest matching entry wins: scan from the top down
    always_comb begin
        lookup_val = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (key_reg[i] == addr_reg) begin
                lookup_val = val_reg[i];
            end
        end
    end

    assign push_val  = DATA_W'(lookup_val);
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign nos_addr  = cnt_m2[ADDR_W-1:0];
    assign ram_we    = cmd.push || cmd.wr_alu;
    assign ram_waddr = cmd.push ? count_reg[ADDR_W-1:0] : nos_addr;
    assign ram_wdata = cmd.push ? push_val : alu_reg;

    sme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_nos),
        .rd_addr (nos_addr),
        .rd_data (nos_data)
    );

    // wrapping 32-bit product, only the low word is kept
    assign prod     = top_reg * nos_data;
    assign alu_next = (op_reg == OP_ADD) ? (top_reg + nos_data) : prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            halt_reg  <= 1'b0;
        end else begin
            if (cmd.push) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.wr_alu) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.set_halt) begin
                halt_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= s_req_type;
            addr_reg <= s_operand_address;
        end
        // top of stack is mirrored in a register; the RAM only serves the second entry
        if (cmd.push) begin
            top_reg <= push_val;
        end else if (cmd.wr_alu) begin
            top_reg <= alu_reg;
        end
        if (cmd.alu) begin
            alu_reg <= alu_next;
        end
        if (cmd.load_out) begin
            out_top_reg    <= (count_reg == '0) ? '0 : top_reg;
            out_shown_reg  <= cmd.shown;
            out_halted_reg <= halt_reg;
            out_fault_reg  <= cmd.fault;
        end
    end

    assign status.op       = op_reg;
    assign status.halted   = halt_reg;
    assign status.cnt_zero = (count_reg == '0);
    assign status.cnt_lt2  = (count_reg < CNT_W'(2));
    assign status.cnt_full = (count_reg >= CNT_W'(STACK_DEPTH));

    assign m_top_value = $signed(out_top_reg);
    assign m_top_shown = out_shown_reg;
    assign m_halted    = out_halted_reg;
    assign m_fault     = out_fault_reg;

endmodule

`default_nettype wire

/* rtl/sme_checker.sv */
// Port-level checker for stack_machine_execute, attached by bind.
// Depends on sme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sme_checker
    import sme_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [DATA_W-1:0]   m_top_value,
    input wire logic                m_top_shown,
    input wire logic                m_halted,
    input wire logic [FAULT_W-1:0]  m_fault
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_top_value) && $stable(m_fault))
        else $error("result beat changed while stalled");

    // instructions are taken one at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second instruction accepted before first finished");

    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fault == FAULT_NONE || m_fault == FAULT_UNDER ||
                     m_fault == FAULT_OVER))
        else $error("undefined fault code");

    a_shown_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_top_shown |-> m_fault == FAULT_NONE && !m_halted)
        else $error("show flagged with fault or after halt");

    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_halted |-> m_fault == FAULT_NONE)
        else $error("fault reported while halted");

endmodule

bind stack_machine_execute sme_checker u_sme_checker (.*);

`default_nettype wire

/* verif/tb_stack_machine_execute.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stack_machine_execute: directed and random instruction
// streams, every result beat checked against an in-bench model of stack and lookup table.
// Depends on sme_pkg and the stack_machine_execute RTL.

module tb_stack_machine_execute;
    import sme_pkg::*;

    localparam int               WATCHDOG_LIMIT = 2000;
    localparam int               DRAIN_CYCLES   = 20;
    localparam logic [KEY_W-1:0] KEY_MAX        = 20'd999999;
    localparam logic [VAL_W-1:0] VALUE_MAX      = 4'd15;
    localparam int               TABLE_REGS     = 4;
    localparam int               RANDOM_ITEMS   = 260;

    // opcodes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_NOP_LOW  = 4'd0;
    localparam logic [OP_W-1:0] OP_NOP_HIGH = 4'd15;

    // register indexes past the table, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_shown;
        logic                     halted;
        logic [FAULT_W-1:0]       fault;
    } machine_result_t;

    logic                     aclk              = 1'b0;
    logic                     aresetn           = 1'b0;
    logic                     s_valid           = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_req_type        = '0;
    logic [KEY_W-1:0]         s_operand_address = '0;
    logic                     m_valid;
    logic                     m_ready           = 1'b0;
    logic signed [DATA_W-1:0] m_top_value;
    logic                     m_top_shown;
    logic                     m_halted;
    logic [FAULT_W-1:0]       m_fault;
    logic                     cfg_valid         = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index         = '0;
    logic [CFG_DATA_W-1:0]    cfg_data          = '0;

    // machine state as the block should hold it
    logic [DATA_W-1:0] model_stack [STACK_DEPTH];
    int                model_depth  = 0;
    bit                model_halted = 1'b0;
    logic [KEY_W-1:0]  model_key [TABLE_REGS] = '{default: '0};
    logic [VAL_W-1:0]  model_val [TABLE_REGS] = '{default: '0};

    machine_result_t awaited_results [$];

    int mismatch_count  = 0;
    int idle_cycles     = 0;
    int hold_off_cycles = 0;
    int stall_left      = 0;
    bit src_idle_on     = 1'b1;
    bit sink_idle_on    = 1'b1;

    stack_machine_execute u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_operand_address (s_operand_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_top_value       (m_top_value),
        .m_top_shown       (m_top_shown),
        .m_halted          (m_halted),
        .m_fault           (m_fault),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'($urandom_range(0, KEY_MAX));
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        return VAL_W'($urandom_range(0, VALUE_MAX));
    endfunction

    // Runs one instruction on the model and returns the result beat it should produce.
    function automatic machine_result_t execute_instruction(input logic [OP_W-1:0] op,
                                                            input logic [KEY_W-1:0] addr);
        machine_result_t  res;
        logic [DATA_W-1:0] tos;
        logic [DATA_W-1:0] nos;
        logic [VAL_W-1:0]  pushed;
        bit                hit;
        res    = '0;
        res.op = op;
        if (!model_halted) begin
            case (op)
                OP_PUSH: begin
                    if (model_depth >= STACK_DEPTH) begin
                        res.fault = FAULT_OVER;
                    end else begin
                        // first matching entry wins, miss pushes zero
                        pushed = '0;
                        hit    = 1'b0;
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (!hit && model_key[i] == addr) begin
                                pushed = model_val[i];
                                hit    = 1'b1;
                            end
                        end
                        model_stack[model_depth] = DATA_W'(pushed);
                        model_depth++;
                    end
                end
                OP_SHOW: begin
                    if (model_depth == 0) res.fault = FAULT_UNDER;
                    else res.top_shown = 1'b1;
                end
                OP_ADD, OP_MULT: begin
                    if (model_depth < 2) begin
                        res.fault = FAULT_UNDER;
                    end else begin
                        tos = model_stack[model_depth-1];
                        nos = model_stack[model_depth-2];
                        model_depth--;
                        model_stack[model_depth-1] = (op == OP_ADD) ? tos + nos : tos * nos;
                    end
                end
                OP_END: begin
                    model_halted = 1'b1;
                end
                default: ;
            endcase
        end
        res.top_value = (model_depth == 0) ? '0 : model_stack[model_depth-1];
        res.halted    = model_halted;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // valid stays up across back-to-back beats, only dropped for a gap
    task automatic send_instruction(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] addr);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_req_type        <= op;
        s_operand_address <= addr;
        do @(posedge aclk); while (!s_ready);
        awaited_results.push_back(execute_instruction(op, addr));
    endtask

    task automatic await_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= CFG_VALUE_THREE) begin
            if (idx[0]) model_val[idx >> 1] = data[VAL_W-1:0];
            else model_key[idx >> 1] = data[KEY_W-1:0];
        end
    endtask

    task automatic load_table(input logic [KEY_W-1:0] k0, input logic [VAL_W-1:0] v0,
                              input logic [KEY_W-1:0] k1, input logic [VAL_W-1:0] v1,
                              input logic [KEY_W-1:0] k2, input logic [VAL_W-1:0] v2,
                              input logic [KEY_W-1:0] k3, input logic [VAL_W-1:0] v3);
        await_idle();
        write_reg(CFG_KEY_ZERO, k0);
        write_reg(CFG_VALUE_ZERO, CFG_DATA_W'(v0));
        write_reg(CFG_KEY_ONE, k1);
        write_reg(CFG_VALUE_ONE, CFG_DATA_W'(v1));
        write_reg(CFG_KEY_TWO, k2);
        write_reg(CFG_VALUE_TWO, CFG_DATA_W'(v2));
        write_reg(CFG_KEY_THREE, k3);
        write_reg(CFG_VALUE_THREE, CFG_DATA_W'(v3));
    endtask

    // Program-like stream: push when shallow, arithmetic when deep, some shows and noise.
    task automatic run_random_program(input int count);
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] addr;
        int               r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                op = OP_W'($urandom_range(0, 15));
                if (op == OP_END) op = OP_SHOW;
            end else if (r < 14) begin
                op = OP_SHOW;
            end else if ($urandom_range(0, STACK_DEPTH) >= model_depth) begin
                op = OP_PUSH;
            end else begin
                op = $urandom_range(0, 1) ? OP_ADD : OP_MULT;
            end
            if ($urandom_range(0, 9) < 7) addr = model_key[$urandom_range(0, TABLE_ENTRIES-1)];
            else addr = random_key();
            send_instruction(op, addr);
        end
    endtask

    task automatic test_empty_stack();
        send_instruction(OP_SHOW, '0);
        send_instruction(OP_ADD, '0);
        send_instruction(OP_MULT, '0);
        send_instruction(OP_NOP_LOW, '0);
        send_instruction(OP_NOP_HIGH, KEY_MAX);
        send_instruction(OP_PUSH, '0);
        send_instruction(OP_ADD, '0);
    endtask

    task automatic test_table_lookup();
        load_table('0, VALUE_MAX, KEY_MAX, '0, 20'd524288, 4'd9, 20'd1, 4'd10);
        send_instruction(OP_PUSH, '0);
        send_instruction(OP_PUSH, KEY_MAX);
        send_instruction(OP_PUSH, 20'd524288);
        send_instruction(OP_PUSH, 20'd1);
        send_instruction(OP_PUSH, 20'd777777);
        send_instruction(OP_SHOW, '0);
    endtask

    task automatic test_full_stack();
        while (model_depth < STACK_DEPTH) send_instruction(OP_PUSH, '0);
        send_instruction(OP_PUSH, '0);
        send_instruction(OP_SHOW, '0);
    endtask

    task automatic test_spare_registers();
        await_idle();
        write_reg(CFG_SPARE_FIRST, KEY_MAX);
        write_reg(CFG_SPARE_LAST, random_key());
        send_instruction(OP_MULT, '0);
        send_instruction(OP_PUSH, KEY_MAX);
        send_instruction(OP_PUSH, '0);
    endtask

    task automatic test_random_table();
        load_table(random_key(), random_value(), random_key(), random_value(),
                   random_key(), random_value(), random_key(), random_value());
        run_random_program(RANDOM_ITEMS);
    endtask

    task automatic test_duplicate_keys();
        logic [KEY_W-1:0] k;
        k = random_key();
        load_table(k, 4'd3, k, 4'd7, k, 4'd11, k, VALUE_MAX);
        run_random_program(RANDOM_ITEMS);
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        load_table(KEY_MAX, VALUE_MAX, '0, '0, KEY_MAX, 4'd9, '0, VALUE_MAX);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_random_program(RANDOM_ITEMS);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        src_idle_on     = 1'b0;
        hold_off_cycles = 300;
        run_random_program(40);
        src_idle_on = 1'b1;
        run_random_program(RANDOM_ITEMS - 40);
    endtask

    task automatic test_halt();
        send_instruction(OP_PUSH, model_key[0]);
        send_instruction(OP_END, random_key());
        send_instruction(OP_PUSH, model_key[0]);
        send_instruction(OP_SHOW, '0);
        send_instruction(OP_ADD, '0);
        send_instruction(OP_MULT, '0);
        send_instruction(OP_NOP_HIGH, '0);
        send_instruction(OP_END, '0);
        await_idle();
        write_reg(CFG_VALUE_ZERO, CFG_DATA_W'(VALUE_MAX));
        send_instruction(OP_PUSH, model_key[0]);
        send_instruction(OP_SHOW, '0);
    endtask

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles--;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        machine_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result beat with no instruction outstanding");
            end else begin
                want = awaited_results.pop_front();
                if (m_top_value !== want.top_value)
                    report_mismatch($sformatf("op %0d top_value got %0d exp %0d",
                                              want.op, m_top_value, want.top_value));
                if (m_top_shown !== want.top_shown)
                    report_mismatch($sformatf("op %0d top_shown got %b exp %b",
                                              want.op, m_top_shown, want.top_shown));
                if (m_halted !== want.halted)
                    report_mismatch($sformatf("op %0d halted got %b exp %b",
                                              want.op, m_halted, want.halted));
                if (m_fault !== want.fault)
                    report_mismatch($sformatf("op %0d fault got %0d exp %0d",
                                              want.op, m_fault, want.fault));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_stack();
        test_table_lookup();
        test_full_stack();
        test_spare_registers();
        test_random_table();
        test_duplicate_keys();
        test_back_to_back();
        test_backpressure();
        test_random_table();
        test_halt();
        await_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
